### src/tfc_pkg.sv
// shared types, constants and crc helper for the tagged frame checker
package tfc_pkg;

  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [POS_W-1:0] HDR_BYTES = 17'd6;
  localparam logic [POS_W-1:0] LAST_MIN_POS = 17'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_TAG   = 3'd2;
  localparam logic [2:0] ST_LEN_ERR   = 3'd3;
  localparam logic [2:0] ST_CRC_ERR   = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [2:0] frame_status;
  } result_t;

  // crc-16/modbus update by one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/tfc_check.sv
// per-frame state and the byte-by-byte checks
module tfc_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic                frame_end,
  input  logic [31:0]         frame_tag,
  output logic                res_valid,
  output tfc_pkg::result_t    res
);

  logic [tfc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      tag_bad_r, tag_bad_nxt;
  logic [15:0]               len_r, len_nxt;
  logic [15:0]               crc_r, crc_nxt;
  logic [7:0]                held0_r, held0_nxt;
  logic [7:0]                held1_r, held1_nxt;

  logic [7:0]                want;
  logic [15:0]               crc_upd;
  logic [15:0]               rx_crc;
  logic [tfc_pkg::POS_W-1:0] pay_off;
  logic [tfc_pkg::POS_W-1:0] len_end;
  logic                      in_payload;

  assign want = frame_tag[{pos_r[1:0], 3'b000} +: 8];
  assign crc_upd = (pos_r >= 17'd2) ? tfc_pkg::crc_byte(crc_r, held1_r) : crc_r;
  assign rx_crc = {byte_in, held0_r};
  assign pay_off = pos_r - tfc_pkg::HDR_BYTES;
  // last byte sits at position 7 + length when the size is right
  assign len_end = tfc_pkg::LAST_MIN_POS + {1'b0, len_r};
  assign in_payload = (pos_r >= tfc_pkg::HDR_BYTES) && (pay_off < {1'b0, len_r});

  always_comb begin
    tag_bad_nxt = tag_bad_r;
    len_nxt     = len_r;
    if (pos_r < 17'd4) begin
      tag_bad_nxt = tag_bad_r | (want != byte_in);
    end else if (pos_r == 17'd4) begin
      len_nxt = {len_r[15:8], byte_in};
    end else if (pos_r == 17'd5) begin
      len_nxt = {byte_in, len_r[7:0]};
    end

    res_valid         = 1'b0;
    res.result_kind   = tfc_pkg::KIND_PAYLOAD;
    res.payload_byte  = 8'h00;
    res.frame_status  = tfc_pkg::ST_OK;

    if (frame_end) begin
      res_valid       = 1'b1;
      res.result_kind = tfc_pkg::KIND_STATUS;
      if (pos_r < tfc_pkg::LAST_MIN_POS) begin
        res.frame_status = tfc_pkg::ST_TOO_SHORT;
      end else if (tag_bad_nxt) begin
        res.frame_status = tfc_pkg::ST_BAD_TAG;
      end else if (pos_r != len_end) begin
        res.frame_status = tfc_pkg::ST_LEN_ERR;
      end else if (crc_upd != rx_crc) begin
        res.frame_status = tfc_pkg::ST_CRC_ERR;
      end
      pos_nxt     = '0;
      tag_bad_nxt = 1'b0;
      len_nxt     = '0;
      crc_nxt     = tfc_pkg::CRC_INIT;
      held0_nxt   = 8'h00;
      held1_nxt   = 8'h00;
    end else begin
      if (in_payload) begin
        res_valid        = 1'b1;
        res.payload_byte = byte_in;
      end
      pos_nxt   = (pos_r == tfc_pkg::POS_MAX) ? pos_r : pos_r + 17'd1;
      crc_nxt   = crc_upd;
      held0_nxt = byte_in;
      held1_nxt = held0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      tag_bad_r <= 1'b0;
      len_r     <= '0;
      crc_r     <= tfc_pkg::CRC_INIT;
      held0_r   <= 8'h00;
      held1_r   <= 8'h00;
    end else if (step) begin
      pos_r     <= pos_nxt;
      tag_bad_r <= tag_bad_nxt;
      len_r     <= len_nxt;
      crc_r     <= crc_nxt;
      held0_r   <= held0_nxt;
      held1_r   <= held1_nxt;
    end
  end

endmodule

### src/tfc_out_reg.sv
// result register in front of the output channel
module tfc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  tfc_pkg::result_t load_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             can_load,
  output tfc_pkg::result_t data
);

  logic             vld_r, vld_nxt;
  tfc_pkg::result_t data_r;

  assign can_load  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign data      = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

### src/tagged_frame_checker_crc16_unit.sv
// top level: input register, frame checker and result register
//
// Frame bytes enter on the in_ channel (valid/ready), one beat per byte, with
// in_frame_end set on the last byte of each frame. A frame is a 4-byte tag,
// a 2-byte length, the payload and a CRC-16/MODBUS, all little-endian.
// Each payload byte leaves as one out_ beat with out_result_kind low; the
// last byte of a frame yields one status beat with out_result_kind high.
// Header bytes give no beat, nor do crc bytes when the length field is right.
// The expected tag is loaded through cfg_we / cfg_frame_tag, which the user
// must do only while no frame bytes are in flight; the block does not enforce
// it. An input beat passes the input register, then the result register,
// with the crc step, tag compare and status decision between them. One byte
// is taken every cycle while out_ready is high. A stall on out_ready with a
// result held keeps it; in_ready drops once the input register holds a byte,
// until the result moves. Reset (rst_n low, synchronous) empties both
// registers, clears the frame state and sets the tag to zero.
module tagged_frame_checker_crc16_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_frame_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_frame_tag
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             in_end_r;
  logic [31:0]      tag_r;
  logic             advance;
  logic             can_load;
  logic             res_valid;
  tfc_pkg::result_t res;
  tfc_pkg::result_t out_data;

  // the held byte is processed when the result register can take its beat
  assign advance  = in_vld_r && can_load;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      tag_r    <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (cfg_we) begin
        tag_r <= cfg_frame_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte_in;
      in_end_r  <= in_frame_end;
    end
  end

  tfc_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .byte_in   (in_byte_r),
    .frame_end (in_end_r),
    .frame_tag (tag_r),
    .res_valid (res_valid),
    .res       (res)
  );

  tfc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .load_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .data      (out_data)
  );

  assign out_result_kind  = out_data.result_kind;
  assign out_payload_byte = out_data.payload_byte;
  assign out_frame_status = out_data.frame_status;

endmodule

### dv/tb_tagged_frame_checker_crc16_unit.sv
// self-checking testbench for the tagged frame checker with crc-16 trailer
`timescale 1ns / 1ps

module tb_tagged_frame_checker_crc16_unit;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'h00;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [2:0]  out_frame_status;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_frame_tag = 32'h0;

  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES_PER_PHASE = 265;

  tagged_frame_checker_crc16_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_status (out_frame_status),
    .cfg_we           (cfg_we),
    .cfg_frame_tag    (cfg_frame_tag)
  );

  // mirror of the frame state
  logic [31:0]               tag_cfg = 32'h0;
  logic [tfc_pkg::POS_W-1:0] frame_pos = '0;
  logic                      tag_bad = 1'b0;
  logic [15:0]               len_field = 16'h0;
  logic [15:0]               crc_acc = tfc_pkg::CRC_INIT;
  logic [7:0]                hold_new = 8'h00;
  logic [7:0]                hold_old = 8'h00;

  tfc_pkg::result_t expected_beats[$];
  logic [7:0]       frame_bytes[$];
  int               errors = 0;
  int               idle_pct = 0;
  int               stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_tagged_frame_checker_crc16_unit failed");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // bit-serial form of the reflected crc update
  function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ d[k]) ? ((r >> 1) ^ tfc_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    frame_pos = '0;
    tag_bad = 1'b0;
    len_field = 16'h0;
    crc_acc = tfc_pkg::CRC_INIT;
    hold_new = 8'h00;
    hold_old = 8'h00;
  endfunction

  // expected output for one accepted input beat
  function automatic void predict_frame_byte(input logic [7:0] b, input logic last);
    logic [tfc_pkg::POS_W-1:0] p;
    logic [tfc_pkg::POS_W:0]   n;
    logic [2:0]                st;
    tfc_pkg::result_t          r;
    p = frame_pos;
    if (p < 4) begin
      if (b != tag_cfg[8*p[1:0] +: 8]) tag_bad = 1'b1;
    end else if (p == 4) begin
      len_field[7:0] = b;
    end else if (p == 5) begin
      len_field[15:8] = b;
    end
    // crc trails by two bytes so the trailer never enters it
    if (p >= 2) crc_acc = modbus_crc_next(crc_acc, hold_old);
    if (last) begin
      n = {1'b0, p} + 1'b1;
      if (n < 8) st = tfc_pkg::ST_TOO_SHORT;
      else if (tag_bad) st = tfc_pkg::ST_BAD_TAG;
      else if (n != 18'd8 + {2'b00, len_field}) st = tfc_pkg::ST_LEN_ERR;
      else if (crc_acc != {b, hold_new}) st = tfc_pkg::ST_CRC_ERR;
      else st = tfc_pkg::ST_OK;
      r.result_kind = tfc_pkg::KIND_STATUS;
      r.payload_byte = 8'h00;
      r.frame_status = st;
      expected_beats.push_back(r);
      clear_frame_state();
    end else begin
      hold_old = hold_new;
      hold_new = b;
      if (frame_pos != tfc_pkg::POS_MAX) frame_pos = frame_pos + 1'b1;
      if (p >= tfc_pkg::HDR_BYTES && (p - tfc_pkg::HDR_BYTES) < {1'b0, len_field}) begin
        r.result_kind = tfc_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
        r.frame_status = tfc_pkg::ST_OK;
        expected_beats.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin : check_results
    tfc_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $error("unexpected result beat: kind %0d byte %0h status %0d",
               out_result_kind, out_payload_byte, out_frame_status);
      end else begin
        want = expected_beats.pop_front();
        if (out_result_kind !== want.result_kind) begin
          errors++;
          $error("result_kind expected %0d actual %0d", want.result_kind, out_result_kind);
        end
        if (out_payload_byte !== want.payload_byte) begin
          errors++;
          $error("payload_byte expected %0h actual %0h", want.payload_byte, out_payload_byte);
        end
        if (out_frame_status !== want.frame_status) begin
          errors++;
          $error("frame_status expected %0d actual %0d", want.frame_status, out_frame_status);
        end
      end
    end
  end

  // all tasks below start and end at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte_in = b;
    in_frame_end = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frame_byte(b, last);
    @(negedge clk);
  endtask

  task automatic hold_until_empty();
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  task automatic wait_drain();
    hold_until_empty();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(input bit allow_pause);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (allow_pause && $urandom_range(199) == 0) hold_until_empty();
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic write_frame_tag(input logic [31:0] value);
    in_valid = 1'b0;
    cfg_we = 1'b1;
    cfg_frame_tag = value;
    @(posedge clk);
    tag_cfg = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic build_frame(input logic [31:0] tag, input logic [15:0] len, input int plen);
    logic [15:0] crc;
    frame_bytes.delete();
    for (int i = 0; i < 4; i++) frame_bytes.push_back(tag[8*i +: 8]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    for (int i = 0; i < plen; i++) frame_bytes.push_back(8'($urandom_range(255)));
    crc = tfc_pkg::CRC_INIT;
    foreach (frame_bytes[i]) crc = modbus_crc_next(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
  endtask

  // tag is zero out of reset: one good empty frame, then a one-byte frame
  task automatic test_reset_tag();
    build_frame(32'h0, 16'h0, 0);
    send_frame(0);
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(255)));
    send_frame(0);
    wait_drain();
  endtask

  // all-ones tag: frame ending inside its payload, then a single tag bit off
  task automatic test_all_ones_tag();
    write_frame_tag(32'hFFFF_FFFF);
    build_frame(32'hFFFF_FFFF, 16'd2, 2);
    frame_bytes[6] = 8'h00;
    frame_bytes[7] = 8'hFF;
    frame_bytes = frame_bytes[0:7];
    send_frame(0);
    build_frame(32'hFFFF_7FFF, 16'h0, 0);
    send_frame(0);
    wait_drain();
  endtask

  // length field at its maximum over a short body, then a long good payload
  task automatic test_long_frames();
    logic [31:0] tag;
    idle_pct = 0;
    stall_pct = 0;
    tag = $urandom();
    write_frame_tag(tag);
    build_frame(tag, 16'hFFFF, 4);
    send_frame(0);
    build_frame(tag, 16'd96, 96);
    send_frame(0);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    logic [31:0] tag;
    int sent;
    int kind;
    int plen;
    int lenf;
    int nbytes;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      wait_drain();
      tag = (ph == 1) ? 32'h0 : (ph == 3) ? 32'hFFFF_FFFF : $urandom();
      write_frame_tag(tag);
      sent = 0;
      while (sent < RANDOM_BYTES_PER_PHASE) begin
        kind = $urandom_range(99);
        plen = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
        if (kind < 60) begin
          build_frame(tag, 16'(plen), plen);
        end else if (kind < 68) begin
          build_frame(tag, 16'(plen), plen);
          frame_bytes[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        end else if (kind < 76) begin
          lenf = $urandom_range(20);
          if (lenf == plen) lenf++;
          build_frame(tag, 16'(lenf), plen);
        end else if (kind < 84) begin
          build_frame(tag, 16'(plen), plen);
          frame_bytes[frame_bytes.size() - 1 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
        end else begin
          // short or garbage frames, random header included
          nbytes = (kind < 92) ? $urandom_range(7, 1) : $urandom_range(40, 1);
          frame_bytes.delete();
          repeat (nbytes) frame_bytes.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(9) == 0) hold_until_empty();
        send_frame(1);
        sent += frame_bytes.size();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_tag();
    test_all_ones_tag();
    test_long_frames();
    test_random_traffic();
    wait_drain();
    if (errors == 0) begin
      $display("tb_tagged_frame_checker_crc16_unit passed");
    end else begin
      $display("tb_tagged_frame_checker_crc16_unit failed");
    end
    $finish;
  end

endmodule
